// ----- design/bptc_pkg.sv -----
// bptc_pkg: shared types, constants and codes for the barometer compensation block
// used by every module in design/; depends on nothing
package bptc_pkg;

    // default depth of the queue between front and back
    localparam int QueueDepth = 2;

    // configuration reset values (datasheet example coefficients, oss = 0)
    localparam logic [47:0] CalAcLoReset = 48'd1756636956625;
    localparam logic [47:0] CalAcHiReset = 48'd140623671024241;
    localparam logic [31:0] CalBReset    = 32'd405667844;
    localparam logic [31:0] CalMReset    = 32'd3724086068;
    localparam logic [1:0]  OssReset     = 2'd0;

    // compensation constants
    localparam logic signed [31:0] TempOffset = 32'sd4000;
    localparam logic signed [31:0] TempRound  = 32'sd8;
    localparam logic signed [31:0] TempMin    = -32'sd2048;
    localparam logic signed [31:0] TempMax    = 32'sd2047;
    localparam logic [31:0]        B4Offset   = 32'd32768;
    localparam logic [15:0]        PressNum   = 16'd50000;
    localparam logic signed [17:0] CoefSq     = 18'sd3038;
    localparam logic signed [17:0] CoefLin    = -18'sd7357;
    localparam logic signed [63:0] CoefOfs    = 64'sd3791;
    localparam logic signed [63:0] PressMax   = 64'sd1048575;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CAL_AC123 = 3'd0,
        REG_CAL_AC456 = 3'd1,
        REG_CAL_B12   = 3'd2,
        REG_CAL_MCMD  = 3'd3,
        REG_OSS       = 3'd4
    } cfg_index_t;

    // one classified reading as queued between front and back
    typedef struct packed {
        logic signed [16:0] dt;   // ut - ac6
        logic [18:0]        up;   // pressure word after the oss shift
    } item_t;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

    // back-end sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_X1,
        ST_X1W,
        ST_TDIV,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_AC2,
        ST_B2L,
        ST_B2H,
        ST_AC3,
        ST_B1L,
        ST_B1H,
        ST_B7,
        ST_B4,
        ST_PDIV,
        ST_PS0,
        ST_PS1,
        ST_PS2,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_FIN,
        ST_DONE
    } core_state_t;

endpackage

// ----- design/bptc_front.sv -----
// bptc_front: accepts raw readings, forms ut - ac6 and the shifted pressure word,
// and holds them in a short queue for the back end; depends on bptc_pkg
module bptc_front #(
    parameter int DEPTH = bptc_pkg::QueueDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [15:0]         raw_temp_word,
    input  logic [23:0]         raw_press_word,
    input  logic [15:0]         ac6,
    input  logic [1:0]          oss,
    input  logic                take,
    output logic                avail,
    output bptc_pkg::item_t     item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bptc_pkg::item_t mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    bptc_pkg::item_t new_item;
    logic [23:0]     up_full;
    logic            do_push;
    logic            do_pop;

    // classify the reading
    always_comb
    begin
        up_full     = raw_press_word >> (4'd8 - {2'b00, oss});
        new_item.dt = $signed({1'b0, raw_temp_word} - {1'b0, ac6});
        new_item.up = up_full[18:0];
    end

    // queue control
    always_comb
    begin
        full        = (count_reg == CW'(DEPTH));
        avail       = (count_reg != '0);
        do_push     = push && !full;
        do_pop      = take && avail;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= new_item;
        end
    end

    assign item = mem[rd_ptr_reg];

endmodule

// ----- design/bptc_div.sv -----
// bptc_div: unsigned 32 by 32 restoring divider, one quotient bit per cycle
// shared by the temperature and pressure steps; depends on bptc_pkg
module bptc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bptc_pkg::div_req_t   req,
    output bptc_pkg::div_rsp_t   rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic [32:0] shifted;
    logic        ge;
    logic [32:0] diff;

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[31]};
        ge      = (shifted >= {1'b0, den_reg});
        diff    = shifted - {1'b0, den_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- design/bptc_core.sv -----
// bptc_core: back-end sequencer, at most one shared 36x18 multiplier step per state and
// the shared divider for the two quotients; depends on bptc_pkg and bptc_div
module bptc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 avail,
    output logic                 take,
    input  bptc_pkg::item_t      item,
    input  logic [47:0]          cal_ac123,
    input  logic [47:0]          cal_ac456,
    input  logic [31:0]          cal_b12,
    input  logic [31:0]          cal_mcmd,
    input  logic [1:0]           oss,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic signed [11:0]   res_temp,
    output logic [19:0]          res_press
);

    bptc_pkg::core_state_t state_reg, state_next;
    bptc_pkg::div_req_t    div_req;
    bptc_pkg::div_rsp_t    div_rsp;

    // calibration fields
    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5;

    // shared multiplier
    logic signed [35:0] ma;
    logic signed [17:0] mb;
    logic signed [53:0] prod_reg;

    // working registers
    logic signed [16:0] dt_reg;
    logic [18:0]        up_reg;
    logic signed [17:0] x1_reg;
    logic               neg_reg;
    logic               denz_reg;
    logic signed [28:0] b6_reg;
    logic signed [11:0] temp_reg;
    logic signed [53:0] acc_reg;
    logic [43:0]        sq_reg;
    logic signed [31:0] x2a_reg;
    logic signed [47:0] b3_reg;
    logic signed [31:0] x1c_reg;
    logic [31:0]        u_reg;
    logic [31:0]        b7_reg;
    logic [33:0]        p_reg;
    logic [51:0]        sqp_reg;
    logic signed [33:0] x2f_reg;
    logic [47:0]        x1f_reg;
    logic [19:0]        press_reg;

    // combinational intermediates
    logic signed [17:0] x1_v;
    logic signed [18:0] den_v;
    logic [31:0]        num_ext, num_mag, den_ext, den_mag;
    logic signed [31:0] x2_v, b5_v, t_v;
    logic signed [11:0] t_clamp;
    logic signed [28:0] b6_v;
    logic signed [63:0] sqs, b2sq, x3a, bv, b3s, b1sq, x3c;
    logic [43:0]        sq_v;
    logic [31:0]        u_v, d7_v;
    logic [15:0]        pcoef;
    logic [33:0]        p_v;
    logic signed [63:0] sqp_s;
    logic [63:0]        tot;
    logic signed [63:0] corr, pf;
    logic [19:0]        press_v;

    assign ac1 = $signed(cal_ac123[47:32]);
    assign ac2 = $signed(cal_ac123[31:16]);
    assign ac3 = $signed(cal_ac123[15:0]);
    assign ac4 = cal_ac456[47:32];
    assign ac5 = cal_ac456[31:16];
    assign b1  = $signed(cal_b12[31:16]);
    assign b2  = $signed(cal_b12[15:0]);
    assign mc  = $signed(cal_mcmd[31:16]);
    assign md  = $signed(cal_mcmd[15:0]);

    bptc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // temperature arithmetic
    always_comb
    begin
        x1_v    = $signed(prod_reg[32:15]);
        den_v   = $signed({x1_v[17], x1_v} + {{3{md[15]}}, md});
        num_ext = {{5{mc[15]}}, mc, 11'b0};
        num_mag = mc[15] ? (~num_ext + 32'd1) : num_ext;
        den_ext = {{13{den_v[18]}}, den_v};
        den_mag = den_v[18] ? (~den_ext + 32'd1) : den_ext;
        if (denz_reg)
        begin
            x2_v = '0;
        end
        else
        begin
            x2_v = neg_reg ? $signed(~div_rsp.quo + 32'd1) : $signed(div_rsp.quo);
        end
        b5_v = 32'(x1_reg) + x2_v;
        t_v  = (b5_v + bptc_pkg::TempRound) >>> 4;
        if (t_v < bptc_pkg::TempMin)
        begin
            t_clamp = 12'(bptc_pkg::TempMin);
        end
        else if (t_v > bptc_pkg::TempMax)
        begin
            t_clamp = 12'(bptc_pkg::TempMax);
        end
        else
        begin
            t_clamp = t_v[11:0];
        end
        b6_v = 29'(b5_v - bptc_pkg::TempOffset);
    end

    // b3, b4 and b7 arithmetic
    always_comb
    begin
        sqs  = (64'(prod_reg) <<< 15) + 64'(acc_reg);
        sq_v = 44'(sqs >>> 12);
        b2sq = (64'(prod_reg) <<< 22) + 64'(acc_reg);
        x3a  = (b2sq >>> 11) + 64'(x2a_reg);
        bv   = (((64'(ac1) <<< 2) + x3a) <<< oss) + 64'sd2;
        b3s  = (bv < 0) ? ((bv + 64'sd3) >>> 2) : (bv >>> 2);
        b1sq = (64'(prod_reg) <<< 22) + 64'(acc_reg);
        x3c  = (64'(x1c_reg) + (b1sq >>> 16) + 64'sd2) >>> 2;
        u_v  = x3c[31:0] + bptc_pkg::B4Offset;
        d7_v = {13'b0, up_reg} - b3_reg[31:0];
        pcoef = bptc_pkg::PressNum >> oss;
    end

    // pressure correction arithmetic
    always_comb
    begin
        p_v   = b7_reg[31] ? {1'b0, div_rsp.quo, 1'b0} : {2'b00, div_rsp.quo};
        sqp_s = (64'(prod_reg) <<< 13) + 64'(acc_reg);
        tot   = (64'(prod_reg[37:0]) << 26) + 64'(acc_reg[37:0]);
        corr  = ($signed({16'b0, x1f_reg}) + 64'(x2f_reg) + bptc_pkg::CoefOfs) >>> 4;
        pf    = $signed({30'b0, p_reg}) + corr;
        if (pf < 0)
        begin
            press_v = '0;
        end
        else if (pf > bptc_pkg::PressMax)
        begin
            press_v = 20'(bptc_pkg::PressMax);
        end
        else
        begin
            press_v = pf[19:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bptc_pkg::ST_IDLE: if (avail) state_next = bptc_pkg::ST_X1;
            bptc_pkg::ST_X1:   state_next = bptc_pkg::ST_X1W;
            bptc_pkg::ST_X1W:  state_next = bptc_pkg::ST_TDIV;
            bptc_pkg::ST_TDIV: if (div_rsp.done) state_next = bptc_pkg::ST_SQ1;
            bptc_pkg::ST_SQ1:  state_next = bptc_pkg::ST_SQ2;
            bptc_pkg::ST_SQ2:  state_next = bptc_pkg::ST_SQ3;
            bptc_pkg::ST_SQ3:  state_next = bptc_pkg::ST_AC2;
            bptc_pkg::ST_AC2:  state_next = bptc_pkg::ST_B2L;
            bptc_pkg::ST_B2L:  state_next = bptc_pkg::ST_B2H;
            bptc_pkg::ST_B2H:  state_next = bptc_pkg::ST_AC3;
            bptc_pkg::ST_AC3:  state_next = bptc_pkg::ST_B1L;
            bptc_pkg::ST_B1L:  state_next = bptc_pkg::ST_B1H;
            bptc_pkg::ST_B1H:  state_next = bptc_pkg::ST_B7;
            bptc_pkg::ST_B7:   state_next = bptc_pkg::ST_B4;
            bptc_pkg::ST_B4:   state_next = bptc_pkg::ST_PDIV;
            bptc_pkg::ST_PDIV: if (div_rsp.done) state_next = bptc_pkg::ST_PS0;
            bptc_pkg::ST_PS0:  state_next = bptc_pkg::ST_PS1;
            bptc_pkg::ST_PS1:  state_next = bptc_pkg::ST_PS2;
            bptc_pkg::ST_PS2:  state_next = bptc_pkg::ST_C1;
            bptc_pkg::ST_C1:   state_next = bptc_pkg::ST_C2;
            bptc_pkg::ST_C2:   state_next = bptc_pkg::ST_C3;
            bptc_pkg::ST_C3:   state_next = bptc_pkg::ST_FIN;
            bptc_pkg::ST_FIN:  state_next = bptc_pkg::ST_DONE;
            bptc_pkg::ST_DONE: if (res_ready) state_next = bptc_pkg::ST_IDLE;
            default:           state_next = bptc_pkg::ST_IDLE;
        endcase
    end

    // per-state outputs: multiplier operands, divider start, handshakes
    always_comb
    begin
        ma        = '0;
        mb        = '0;
        take      = 1'b0;
        res_valid = 1'b0;
        div_req   = '0;
        case (state_reg)
            bptc_pkg::ST_IDLE:
            begin
                take = avail;
            end
            bptc_pkg::ST_X1:
            begin
                ma = 36'(dt_reg);
                mb = {2'b00, ac5};
            end
            bptc_pkg::ST_X1W:
            begin
                div_req.start = 1'b1;
                div_req.num   = num_mag;
                div_req.den   = den_mag;
            end
            bptc_pkg::ST_SQ1:
            begin
                ma = 36'(b6_reg);
                mb = {3'b000, b6_reg[14:0]};
            end
            bptc_pkg::ST_SQ2:
            begin
                ma = 36'(b6_reg);
                mb = 18'($signed(b6_reg[28:15]));
            end
            bptc_pkg::ST_SQ3:
            begin
                ma = 36'(b6_reg);
                mb = 18'(ac2);
            end
            bptc_pkg::ST_AC2:
            begin
                ma = {14'b0, sq_reg[21:0]};
                mb = 18'(b2);
            end
            bptc_pkg::ST_B2L:
            begin
                ma = {14'b0, sq_reg[43:22]};
                mb = 18'(b2);
            end
            bptc_pkg::ST_B2H:
            begin
                ma = 36'(b6_reg);
                mb = 18'(ac3);
            end
            bptc_pkg::ST_AC3:
            begin
                ma = {14'b0, sq_reg[21:0]};
                mb = 18'(b1);
            end
            bptc_pkg::ST_B1L:
            begin
                ma = {14'b0, sq_reg[43:22]};
                mb = 18'(b1);
            end
            bptc_pkg::ST_B1H:
            begin
                ma = {4'b0, d7_v};
                mb = {2'b00, pcoef};
            end
            bptc_pkg::ST_B7:
            begin
                ma = {4'b0, u_reg};
                mb = {2'b00, ac4};
            end
            bptc_pkg::ST_B4:
            begin
                div_req.start = 1'b1;
                div_req.num   = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
                div_req.den   = prod_reg[46:15];
            end
            bptc_pkg::ST_PS0:
            begin
                ma = {10'b0, p_reg[33:8]};
                mb = {5'b0, p_reg[20:8]};
            end
            bptc_pkg::ST_PS1:
            begin
                ma = {10'b0, p_reg[33:8]};
                mb = {5'b0, p_reg[33:21]};
            end
            bptc_pkg::ST_PS2:
            begin
                ma = {2'b00, p_reg};
                mb = bptc_pkg::CoefLin;
            end
            bptc_pkg::ST_C1:
            begin
                ma = {10'b0, sqp_reg[25:0]};
                mb = bptc_pkg::CoefSq;
            end
            bptc_pkg::ST_C2:
            begin
                ma = {10'b0, sqp_reg[51:26]};
                mb = bptc_pkg::CoefSq;
            end
            bptc_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                ma = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bptc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers, each state consumes the product of the one before
    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        case (state_reg)
            bptc_pkg::ST_IDLE:
            begin
                if (avail)
                begin
                    dt_reg <= item.dt;
                    up_reg <= item.up;
                end
            end
            bptc_pkg::ST_X1W:
            begin
                x1_reg   <= x1_v;
                neg_reg  <= mc[15] ^ den_v[18];
                denz_reg <= (den_v == '0);
            end
            bptc_pkg::ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    temp_reg <= t_clamp;
                    b6_reg   <= b6_v;
                end
            end
            bptc_pkg::ST_SQ2: acc_reg <= prod_reg;
            bptc_pkg::ST_SQ3: sq_reg  <= sq_v;
            bptc_pkg::ST_AC2: x2a_reg <= 32'(prod_reg >>> 11);
            bptc_pkg::ST_B2L: acc_reg <= prod_reg;
            bptc_pkg::ST_B2H: b3_reg  <= 48'(b3s);
            bptc_pkg::ST_AC3: x1c_reg <= 32'(prod_reg >>> 13);
            bptc_pkg::ST_B1L: acc_reg <= prod_reg;
            bptc_pkg::ST_B1H: u_reg   <= u_v;
            bptc_pkg::ST_B7:  b7_reg  <= prod_reg[31:0];
            bptc_pkg::ST_PDIV:
            begin
                if (div_rsp.done)
                begin
                    p_reg <= p_v;
                end
            end
            bptc_pkg::ST_PS1: acc_reg   <= prod_reg;
            bptc_pkg::ST_PS2: sqp_reg   <= 52'(sqp_s);
            bptc_pkg::ST_C1:  x2f_reg   <= 34'(prod_reg >>> 16);
            bptc_pkg::ST_C2:  acc_reg   <= prod_reg;
            bptc_pkg::ST_C3:  x1f_reg   <= tot[63:16];
            bptc_pkg::ST_FIN: press_reg <= press_v;
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign res_temp  = temp_reg;
    assign res_press = press_reg;

endmodule

// ----- design/baro_temp_pressure_compensation.sv -----
// baro_temp_pressure_compensation: top level with calibration registers and result register
// depends on bptc_pkg, bptc_front, bptc_core (and bptc_div below it)
//
//  channel   handshake              payload
//  input     push / full            raw_temp_word, raw_press_word
//  result    empty / pop            temperature_decideg, pressure_pa
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each reading passes the back end as two quotients on the one bit-serial divider
// plus 22 further sequencer steps; the last step holds until the result register can take it
// the front queue keeps taking readings while the back end works; one finished
// result waits in the output register while the next is computed
// reset clears queue, sequencer and result valid and loads the example calibration
module baro_temp_pressure_compensation #(
    parameter int QUEUE_DEPTH = bptc_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        raw_temp_word,
    input  logic [23:0]        raw_press_word,
    output logic               empty,
    input  logic               pop,
    output logic signed [11:0] temperature_decideg,
    output logic [19:0]        pressure_pa,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);

    logic [47:0]        cal_ac123_reg;
    logic [47:0]        cal_ac456_reg;
    logic [31:0]        cal_b12_reg;
    logic [31:0]        cal_mcmd_reg;
    logic [1:0]         oss_reg;
    logic               out_valid_reg;
    logic signed [11:0] out_temp_reg;
    logic [19:0]        out_press_reg;

    logic               avail;
    logic               take;
    bptc_pkg::item_t    item;
    logic               res_valid;
    logic               res_ready;
    logic signed [11:0] res_temp;
    logic [19:0]        res_press;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_ac123_reg <= bptc_pkg::CalAcLoReset;
            cal_ac456_reg <= bptc_pkg::CalAcHiReset;
            cal_b12_reg   <= bptc_pkg::CalBReset;
            cal_mcmd_reg  <= bptc_pkg::CalMReset;
            oss_reg       <= bptc_pkg::OssReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bptc_pkg::REG_CAL_AC123: cal_ac123_reg <= cfg_data;
                bptc_pkg::REG_CAL_AC456: cal_ac456_reg <= cfg_data;
                bptc_pkg::REG_CAL_B12:   cal_b12_reg   <= cfg_data[31:0];
                bptc_pkg::REG_CAL_MCMD:  cal_mcmd_reg  <= cfg_data[31:0];
                bptc_pkg::REG_OSS:       oss_reg       <= cfg_data[1:0];
                default:                 oss_reg       <= oss_reg;
            endcase
        end
    end

    bptc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .raw_temp_word  (raw_temp_word),
        .raw_press_word (raw_press_word),
        .ac6            (cal_ac456_reg[15:0]),
        .oss            (oss_reg),
        .take           (take),
        .avail          (avail),
        .item           (item)
    );

    bptc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .take      (take),
        .item      (item),
        .cal_ac123 (cal_ac123_reg),
        .cal_ac456 (cal_ac456_reg),
        .cal_b12   (cal_b12_reg),
        .cal_mcmd  (cal_mcmd_reg),
        .oss       (oss_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_temp  (res_temp),
        .res_press (res_press)
    );

    // result register
    assign res_ready = !out_valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_temp_reg  <= res_temp;
            out_press_reg <= res_press;
        end
    end

    assign empty               = !out_valid_reg;
    assign temperature_decideg = out_temp_reg;
    assign pressure_pa         = out_press_reg;

endmodule

// ----- test/baro_temp_pressure_compensation_tb.sv -----
// testbench for baro_temp_pressure_compensation: random and directed readings across calibrations
// holds its own integer compensation predictor; depends on bptc_pkg and the design files
module baro_temp_pressure_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 6000;
    localparam int HoldCycles = 400;

    typedef struct {
        logic signed [11:0] temp;
        logic [19:0]        press;
    } reading_t;

    // expected readings and the compensation arithmetic that produces them
    class compensation_scoreboard;
        logic [47:0] cal_ac123 = bptc_pkg::CalAcLoReset;
        logic [47:0] cal_ac456 = bptc_pkg::CalAcHiReset;
        logic [31:0] cal_b12   = bptc_pkg::CalBReset;
        logic [31:0] cal_mcmd  = bptc_pkg::CalMReset;
        logic [1:0]  oss       = bptc_pkg::OssReset;
        reading_t    expected_readings[$];
        int          mismatches = 0;

        function void write_reg(bptc_pkg::cfg_index_t idx, logic [47:0] v);
            case (idx)
                bptc_pkg::REG_CAL_AC123: cal_ac123 = v;
                bptc_pkg::REG_CAL_AC456: cal_ac456 = v;
                bptc_pkg::REG_CAL_B12:   cal_b12 = v[31:0];
                bptc_pkg::REG_CAL_MCMD:  cal_mcmd = v[31:0];
                bptc_pkg::REG_OSS:       oss = v[1:0];
                default: ;
            endcase
        endfunction

        // integer compensation of one accepted reading
        function void note_reading(logic [15:0] ut_w, logic [23:0] up_w);
            longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            longint ut, up, x1, x2, x3, den, b3, b5, b6, sq, t, p;
            longint unsigned prod;
            int unsigned x3u, diff, scale, b4, b7, dbl, q;
            reading_t r;
            ac1 = longint'($signed(cal_ac123[47:32]));
            ac2 = longint'($signed(cal_ac123[31:16]));
            ac3 = longint'($signed(cal_ac123[15:0]));
            ac4 = longint'(cal_ac456[47:32]);
            ac5 = longint'(cal_ac456[31:16]);
            ac6 = longint'(cal_ac456[15:0]);
            b1 = longint'($signed(cal_b12[31:16]));
            b2 = longint'($signed(cal_b12[15:0]));
            mc = longint'($signed(cal_mcmd[31:16]));
            md = longint'($signed(cal_mcmd[15:0]));
            ut = longint'(ut_w);
            up = longint'(up_w) >>> (8 - int'(oss));

            // temperature
            x1 = ((ut - ac6) * ac5) >>> 15;
            den = x1 + md;
            x2 = (den != 0) ? (mc * 2048) / den : 0;
            b5 = x1 + x2;
            t = (b5 + 8) >>> 4;

            // pressure offsets
            b6 = b5 - 4000;
            sq = (b6 * b6) >>> 12;
            x1 = (b2 * sq) >>> 11;
            x2 = (ac2 * b6) >>> 11;
            x3 = x1 + x2;
            b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
            x1 = (ac3 * b6) >>> 13;
            x2 = (b1 * sq) >>> 16;
            x3 = (x1 + x2 + 2) >>> 2;
            x3u = 32'(x3 + 32768);
            prod = (64'(ac4) * 64'(x3u)) >> 15;
            b4 = prod[31:0];
            diff = 32'(up - b3);
            scale = 32'd50000 >> oss;
            b7 = diff * scale;

            // quotient, with an all-ones result for a zero divisor
            if (b7 < 32'h8000_0000)
            begin
                dbl = b7 << 1;
                q = (b4 != 0) ? dbl / b4 : 32'hFFFF_FFFF;
                p = {32'b0, q};
            end
            else
            begin
                q = (b4 != 0) ? b7 / b4 : 32'hFFFF_FFFF;
                p = {32'b0, q} * 2;
            end
            x1 = (p >>> 8) * (p >>> 8);
            x1 = (x1 * 3038) >>> 16;
            x2 = (-7357 * p) >>> 16;
            p = p + ((x1 + x2 + 3791) >>> 4);

            // saturate to the output fields
            if (t < -2048) t = -2048;
            if (t > 2047) t = 2047;
            if (p < 0) p = 0;
            if (p > 1048575) p = 1048575;
            r.temp = t[11:0];
            r.press = p[19:0];
            expected_readings.push_back(r);
        endfunction

        function void check_result(logic signed [11:0] temp, logic [19:0] press);
            reading_t r;
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result temp=%0d press=%0d", temp, press);
                return;
            end
            r = expected_readings.pop_front();
            if (temp !== r.temp || press !== r.press)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch temp exp=%0d got=%0d press exp=%0d got=%0d",
                             r.temp, temp, r.press, press);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [15:0]        raw_temp_word;
    logic [23:0]        raw_press_word;
    logic               empty;
    logic               pop;
    logic signed [11:0] temperature_decideg;
    logic [19:0]        pressure_pa;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [47:0]        cfg_data;

    compensation_scoreboard sb = new();
    bit hold_req = 0;
    int idle_cycles = 0;

    baro_temp_pressure_compensation dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .raw_temp_word(raw_temp_word), .raw_press_word(raw_press_word),
        .empty(empty), .pop(pop),
        .temperature_decideg(temperature_decideg), .pressure_pa(pressure_pa),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // result side: check accepted results, count idle cycles
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(temperature_decideg, pressure_pa);
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (idle_cycles >= IdleLimit);
        $display("status: fail");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        pop <= 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 0;
                repeat (HoldCycles) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    0: pop <= 1;
                    1: pop <= $urandom_range(0, 1);
                    2: pop <= ($urandom_range(0, 7) != 0);
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // one reading through the push side; push stays high for the next item
    task automatic send_reading(logic [15:0] ut_w, logic [23:0] up_w);
        push <= 1;
        raw_temp_word <= ut_w;
        raw_press_word <= up_w;
        do @(posedge clk); while (full);
        sb.note_reading(ut_w, up_w);
    endtask

    task automatic drain_results();
        push <= 0;
        @(posedge clk);
        while (sb.expected_readings.size() != 0) @(posedge clk);
    endtask

    // one register write; valid stays high for the next write
    task automatic write_reg(bptc_pkg::cfg_index_t idx, logic [47:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, v);
    endtask

    task automatic write_all(logic [47:0] a, logic [47:0] b, logic [31:0] c,
                             logic [31:0] d, logic [1:0] o);
        write_reg(bptc_pkg::REG_CAL_AC123, a);
        write_reg(bptc_pkg::REG_CAL_AC456, b);
        write_reg(bptc_pkg::REG_CAL_B12, {16'h0, c});
        write_reg(bptc_pkg::REG_CAL_MCMD, {16'h0, d});
        write_reg(bptc_pkg::REG_OSS, {46'h0, o});
        cfg_valid <= 0;
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // random readings in bursts; about half near a plausible operating point, the rest fully random
    task automatic random_burst(int count);
        int burst;
        logic [15:0] ut_w;
        logic [23:0] up_w;
        burst = $urandom_range(1, 12);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                ut_w = 16'd27898 + 16'($signed($urandom_range(0, 8000)) - 4000);
                up_w = 24'(({8'h0, 24'($urandom_range(20000, 40000))}) << 8)
                       ^ 24'($urandom_range(0, 255));
            end
            else
            begin
                ut_w = 16'($urandom);
                up_w = 24'($urandom);
            end
            send_reading(ut_w, up_w);
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0)
                begin
                    push <= 0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
            end
        end
    endtask

    // stimulus
    initial
    begin
        logic [47:0] a, b;
        logic [31:0] c, d;
        rst_n <= 0;
        push <= 0;
        raw_temp_word <= 0;
        raw_press_word <= 0;
        cfg_valid <= 0;
        cfg_index <= bptc_pkg::REG_CAL_AC123;
        cfg_data <= 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed readings with the example calibration
        send_reading(16'd27898, 24'd23843 << 8);
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h0000, 24'hFFFFFF);
        send_reading(16'hFFFF, 24'h000000);
        send_reading(16'hAAAA, 24'h555555);
        send_reading(16'h5555, 24'hAAAAAA);
        drain_results();

        // zero divisors on both paths, deepest oversampling
        write_all(bptc_pkg::CalAcLoReset, {16'd0, 16'd32768, 16'd0}, bptc_pkg::CalBReset,
                  {16'd2000, 16'hFF9C}, 2'd3);
        send_reading(16'd100, 24'h7FFFFF);
        send_reading(16'd100, 24'h000000);
        send_reading(16'd101, 24'hFFFFFF);
        drain_results();

        // example calibration at the other oversampling extreme
        write_all(bptc_pkg::CalAcLoReset, bptc_pkg::CalAcHiReset, bptc_pkg::CalBReset,
                  bptc_pkg::CalMReset, 2'd3);
        send_reading(16'd27898, 24'd23843 << 5);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h0000, 24'h000000);
        drain_results();

        // calibration extremes
        write_all('0, '0, '0, '0, 2'd0);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h1234, 24'h800000);
        drain_results();
        write_all('1, '1, '1, '1, 2'd3);
        send_reading(16'hFFFF, 24'hFFFFFF);
        send_reading(16'h0000, 24'h000000);
        drain_results();

        // random phases, each with its own calibration
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph % 3 == 2)
            begin
                a = rand48();
                b = rand48();
                c = $urandom;
                d = $urandom;
            end
            else
            begin
                a = bptc_pkg::CalAcLoReset
                    ^ 48'({$urandom_range(0, 255), 8'h0, $urandom_range(0, 63)});
                b = bptc_pkg::CalAcHiReset ^ 48'($urandom_range(0, 1023));
                c = bptc_pkg::CalBReset ^ 32'($urandom_range(0, 255));
                d = bptc_pkg::CalMReset ^ 32'($urandom_range(0, 127));
            end
            write_all(a, b, c, d, 2'(ph));
            if (ph == 4)
                hold_req = 1;
            random_burst(80);
            drain_results();
        end

        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_readings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
